// ===== rtl/sorted_sequence_merge_macros.svh =====
// ----------------------------------------------------------------------------
// sorted_sequence_merge_macros
// assertion macros shared by the sorted sequence merge rtl
// ----------------------------------------------------------------------------
`ifndef SORTED_SEQUENCE_MERGE_MACROS_SVH
`define SORTED_SEQUENCE_MERGE_MACROS_SVH

// same-cycle implication, disabled while reset is asserted
`define SSM_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("ssm assertion failed");

// next-cycle implication, disabled while reset is asserted
`define SSM_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("ssm assertion failed");

`endif

// ===== rtl/ssm_pkg.sv =====
// ----------------------------------------------------------------------------
// ssm_pkg
// shared constants, types and function codes of the sorted sequence merge
// ----------------------------------------------------------------------------
package ssm_pkg;

  // store geometry
  localparam int DEPTH  = 32;
  localparam int WIDTH  = 32;
  localparam int CNT_W  = $clog2(DEPTH + 1);
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  typedef logic signed [WIDTH-1:0] elem_t;
  typedef logic [CNT_W-1:0]        cnt_t;
  typedef logic [ADDR_W-1:0]       addr_t;

  // function codes of an input transaction
  typedef enum logic [1:0] {
    FN_APPEND_A = 2'd0,
    FN_APPEND_B = 2'd1,
    FN_MERGE    = 2'd2
  } func_t;

  // result of one compare step
  typedef struct packed {
    logic  sel_a;
    logic  last;
    elem_t value;
  } pick_t;

endpackage

// ===== rtl/ssm_store.sv =====
// ----------------------------------------------------------------------------
// ssm_store
// one sequence store: one write port, one read port with registered data
// ----------------------------------------------------------------------------
module ssm_store
  import ssm_pkg::*;
(
  input  logic  clk,
  input  logic  we,
  input  addr_t waddr,
  input  elem_t wdata,
  input  addr_t raddr,
  output elem_t rdata
);

  elem_t mem [DEPTH];
  elem_t rdata_r;

  // write and registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ===== rtl/ssm_pick.sv =====
// ----------------------------------------------------------------------------
// ssm_pick
// compare unit: chooses the next head of the merge and flags the last one
// ----------------------------------------------------------------------------
module ssm_pick
  import ssm_pkg::*;
(
  input  elem_t head_a,
  input  elem_t head_b,
  input  cnt_t  idx_a,
  input  cnt_t  idx_b,
  input  cnt_t  cnt_a,
  input  cnt_t  cnt_b,
  output pick_t pick
);

  logic a_left;
  logic b_left;
  cnt_t idx_a_nxt;
  cnt_t idx_b_nxt;

  // take a while it has elements and either b is exhausted or a's head is not above b's head
  always_comb begin
    a_left     = idx_a < cnt_a;
    b_left     = idx_b < cnt_b;
    pick.sel_a = a_left && (!b_left || (head_a <= head_b));
    pick.value = pick.sel_a ? head_a : head_b;
    idx_a_nxt  = idx_a + cnt_t'(pick.sel_a);
    idx_b_nxt  = idx_b + cnt_t'(!pick.sel_a);
    pick.last  = (idx_a_nxt == cnt_a) && (idx_b_nxt == cnt_b);
  end

endmodule

// ===== rtl/sorted_sequence_merge.sv =====
// ----------------------------------------------------------------------------
// sorted_sequence_merge
// two-way stable merge of two sorted sequences held in on-chip stores
// ----------------------------------------------------------------------------
// channel  direction  ports                                        handshake
// in       input      in_func, in_value                            in_valid/in_stall
// out      output     out_value_out, out_last, out_empty_res,      out_valid/out_stall
//                     out_overflow
//
// an append is accepted in the idle state; a merge passes from the accepting
// idle state through one read state, then a compare and an emit state per
// element, set by the single compare unit and the registered read port
// of each store. an empty merge goes from the accepting state straight to
// the emit state. reset is synchronous, needs no clearing pass, and empties
// both sequences. out_stall holds the current transaction and the
// sequencer; in_stall is high until a merge is drained.
// ----------------------------------------------------------------------------
`include "sorted_sequence_merge_macros.svh"

module sorted_sequence_merge
  import ssm_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_func,
  input  logic [31:0] in_value,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] out_value_out,
  output logic        out_last,
  output logic        out_empty_res,
  output logic        out_overflow
);

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_READ = 4'b0010,
    S_PICK = 4'b0100,
    S_EMIT = 4'b1000
  } state_t;

  state_t state_r, state_nxt;
  cnt_t   cnt_a_r, cnt_a_nxt;
  cnt_t   cnt_b_r, cnt_b_nxt;
  cnt_t   idx_a_r, idx_a_nxt;
  cnt_t   idx_b_r, idx_b_nxt;
  logic   dropped_r, dropped_nxt;
  logic   out_valid_r, out_valid_nxt;
  elem_t  out_elem_r, out_elem_nxt;
  logic   out_last_r, out_last_nxt;
  logic   out_empty_r, out_empty_nxt;
  logic   out_ovf_r, out_ovf_nxt;

  logic   in_fire;
  logic   out_fire;
  logic   we_a;
  logic   we_b;
  elem_t  wr_elem;
  elem_t  head_a;
  elem_t  head_b;
  pick_t  pick;

  assign in_fire  = in_valid && !in_stall;
  assign out_fire = out_valid_r && !out_stall;
  assign wr_elem  = WIDTH'(signed'(in_value));

  // append writes, dropped when the sequence is full
  assign we_a = in_fire && (in_func == FN_APPEND_A) && (cnt_a_r < cnt_t'(DEPTH));
  assign we_b = in_fire && (in_func == FN_APPEND_B) && (cnt_b_r < cnt_t'(DEPTH));

  // sequence stores, read at the current merge heads
  ssm_store u_store_a (
    .clk   (clk),
    .we    (we_a),
    .waddr (cnt_a_r[ADDR_W-1:0]),
    .wdata (wr_elem),
    .raddr (idx_a_r[ADDR_W-1:0]),
    .rdata (head_a)
  );

  ssm_store u_store_b (
    .clk   (clk),
    .we    (we_b),
    .waddr (cnt_b_r[ADDR_W-1:0]),
    .wdata (wr_elem),
    .raddr (idx_b_r[ADDR_W-1:0]),
    .rdata (head_b)
  );

  // shared compare unit
  ssm_pick u_pick (
    .head_a (head_a),
    .head_b (head_b),
    .idx_a  (idx_a_r),
    .idx_b  (idx_b_r),
    .cnt_a  (cnt_a_r),
    .cnt_b  (cnt_b_r),
    .pick   (pick)
  );

  // sequencer
  always_comb begin
    state_nxt     = state_r;
    cnt_a_nxt     = cnt_a_r;
    cnt_b_nxt     = cnt_b_r;
    idx_a_nxt     = idx_a_r;
    idx_b_nxt     = idx_b_r;
    dropped_nxt   = dropped_r;
    out_valid_nxt = out_valid_r;
    out_elem_nxt  = out_elem_r;
    out_last_nxt  = out_last_r;
    out_empty_nxt = out_empty_r;
    out_ovf_nxt   = out_ovf_r;
    case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          case (in_func)
            FN_APPEND_A: begin
              if (we_a) cnt_a_nxt = cnt_a_r + cnt_t'(1);
              else      dropped_nxt = 1'b1;
            end
            FN_APPEND_B: begin
              if (we_b) cnt_b_nxt = cnt_b_r + cnt_t'(1);
              else      dropped_nxt = 1'b1;
            end
            FN_MERGE: begin
              if ((cnt_a_r == '0) && (cnt_b_r == '0)) begin
                out_valid_nxt = 1'b1;
                out_elem_nxt  = '0;
                out_last_nxt  = 1'b1;
                out_empty_nxt = 1'b1;
                out_ovf_nxt   = dropped_r;
                state_nxt     = S_EMIT;
              end else begin
                state_nxt = S_READ;
              end
            end
            default: ;
          endcase
        end
      end
      S_READ: begin
        state_nxt = S_PICK;
      end
      S_PICK: begin
        out_valid_nxt = 1'b1;
        out_elem_nxt  = pick.value;
        out_last_nxt  = pick.last;
        out_empty_nxt = 1'b0;
        out_ovf_nxt   = pick.last && dropped_r;
        idx_a_nxt     = idx_a_r + cnt_t'(pick.sel_a);
        idx_b_nxt     = idx_b_r + cnt_t'(!pick.sel_a);
        state_nxt     = S_EMIT;
      end
      S_EMIT: begin
        if (out_fire) begin
          out_valid_nxt = 1'b0;
          if (out_last_r) begin
            cnt_a_nxt   = '0;
            cnt_b_nxt   = '0;
            idx_a_nxt   = '0;
            idx_b_nxt   = '0;
            dropped_nxt = 1'b0;
            state_nxt   = S_IDLE;
          end else begin
            state_nxt = S_PICK;
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_a_r     <= '0;
      cnt_b_r     <= '0;
      idx_a_r     <= '0;
      idx_b_r     <= '0;
      dropped_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_a_r     <= cnt_a_nxt;
      cnt_b_r     <= cnt_b_nxt;
      idx_a_r     <= idx_a_nxt;
      idx_b_r     <= idx_b_nxt;
      dropped_r   <= dropped_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // result payload registers
  always_ff @(posedge clk) begin
    out_elem_r  <= out_elem_nxt;
    out_last_r  <= out_last_nxt;
    out_empty_r <= out_empty_nxt;
    out_ovf_r   <= out_ovf_nxt;
  end

  assign in_stall      = (state_r != S_IDLE);
  assign out_valid     = out_valid_r;
  assign out_value_out = 32'(out_elem_r);
  assign out_last      = out_last_r;
  assign out_empty_res = out_empty_r;
  assign out_overflow  = out_ovf_r;

  // checks
  `SSM_ASSERT_NOW(a_idle_no_result, clk, rst_n, !in_stall, !out_valid_r)
  `SSM_ASSERT_NOW(a_pick_has_elem, clk, rst_n, state_r == S_PICK,
                  (idx_a_r < cnt_a_r) || (idx_b_r < cnt_b_r))
  `SSM_ASSERT_NOW(a_count_bound, clk, rst_n, 1'b1,
                  (cnt_a_r <= cnt_t'(DEPTH)) && (cnt_b_r <= cnt_t'(DEPTH)))
  `SSM_ASSERT_NOW(a_empty_is_last, clk, rst_n, out_valid_r && out_empty_r, out_last_r)
  `SSM_ASSERT_NEXT(a_last_clears, clk, rst_n, out_fire && out_last_r,
                   (state_r == S_IDLE) && (cnt_a_r == '0) && (cnt_b_r == '0) && !dropped_r)

endmodule

// ===== verif/ssm_merge_checker.sv =====
// ----------------------------------------------------------------------------
// ssm_merge_checker
// watches both channels of the sorted sequence merge, keeps its own copy of
// the two sequence stores, predicts every merged result and compares each
// accepted result transaction with the oldest prediction
// ----------------------------------------------------------------------------
module ssm_merge_checker
  import ssm_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic [1:0]  in_func,
  input  logic [31:0] in_value,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic [31:0] out_value_out,
  input  logic        out_last,
  input  logic        out_empty_res,
  input  logic        out_overflow,
  output int          fail_count,
  output int          pending
);
  timeunit 1ns;
  timeprecision 1ps;

  // one predicted result transaction
  typedef struct {
    logic [31:0] value_out;
    logic        last;
    logic        empty_res;
    logic        overflow;
  } merge_item_t;

  merge_item_t merged_q[$];

  // shadow copy of both sequences
  elem_t seq_a[DEPTH];
  elem_t seq_b[DEPTH];
  int    len_a;
  int    len_b;
  logic  dropped;

  always @(posedge clk) begin : track
    merge_item_t want;
    elem_t       pick;
    int          ia;
    int          ib;
    int          total;
    if (!rst_n) begin
      len_a      = 0;
      len_b      = 0;
      dropped    = 1'b0;
      fail_count = 0;
      merged_q.delete();
    end else begin
      // result side: compare with the oldest prediction
      if (out_valid && !out_stall) begin
        if (merged_q.size() == 0) begin
          $error("unexpected result transaction, value_out %0d", $signed(out_value_out));
          fail_count++;
        end else begin
          want = merged_q.pop_front();
          if (out_value_out !== want.value_out) begin
            $error("value_out mismatch: expected %0d, actual %0d",
                   $signed(want.value_out), $signed(out_value_out));
            fail_count++;
          end
          if (out_last !== want.last) begin
            $error("last mismatch: expected %0d, actual %0d", want.last, out_last);
            fail_count++;
          end
          if (out_empty_res !== want.empty_res) begin
            $error("empty_res mismatch: expected %0d, actual %0d",
                   want.empty_res, out_empty_res);
            fail_count++;
          end
          if (out_overflow !== want.overflow) begin
            $error("overflow mismatch: expected %0d, actual %0d",
                   want.overflow, out_overflow);
            fail_count++;
          end
        end
      end

      // input side: update the shadow stores, predict merges
      if (in_valid && !in_stall) begin
        if (in_func == FN_APPEND_A) begin
          if (len_a < DEPTH) begin
            seq_a[len_a] = elem_t'($signed(in_value));
            len_a++;
          end else begin
            dropped = 1'b1;
          end
        end else if (in_func == FN_APPEND_B) begin
          if (len_b < DEPTH) begin
            seq_b[len_b] = elem_t'($signed(in_value));
            len_b++;
          end else begin
            dropped = 1'b1;
          end
        end else if (in_func == FN_MERGE) begin
          total = len_a + len_b;
          if (total == 0) begin
            // both sequences empty: a single flagged transaction
            want = '{32'd0, 1'b1, 1'b1, dropped};
            merged_q.insert(merged_q.size(), want);
          end else begin
            // stable merge, head of a wins ties
            ia = 0;
            ib = 0;
            for (int k = 0; k < total; k++) begin
              if (ia < len_a && (ib >= len_b || seq_a[ia] <= seq_b[ib])) begin
                pick = seq_a[ia];
                ia++;
              end else begin
                pick = seq_b[ib];
                ib++;
              end
              want.value_out = 32'(pick);
              want.last      = (k == total - 1);
              want.empty_res = 1'b0;
              want.overflow  = (k == total - 1) ? dropped : 1'b0;
              merged_q.insert(merged_q.size(), want);
            end
          end
          len_a   = 0;
          len_b   = 0;
          dropped = 1'b0;
        end
      end
    end
    pending = merged_q.size();
  end

endmodule

// ===== verif/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// drives the sorted sequence merge with directed and random append and merge
// transactions under random idling on both channels, and reports the verdict
// from the failure count of the checker
// ----------------------------------------------------------------------------
module tb
  import ssm_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  // function code the block ignores
  localparam logic [1:0] FN_UNUSED = 2'd3;

  localparam int     RAND_ITEMS = 230;
  localparam int     QUIET_FROM = 190;
  localparam longint ELEM_MAX   = 64'sd2147483647;

  logic        clk;
  logic        rst_n     = 1'b0;
  logic        in_valid  = 1'b0;
  logic        in_stall;
  logic [1:0]  in_func   = FN_APPEND_A;
  logic [31:0] in_value  = 32'd0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [31:0] out_value_out;
  logic        out_last;
  logic        out_empty_res;
  logic        out_overflow;

  int fail_count;
  int pending;
  int items_sent = 0;
  bit idle_on    = 1'b0;
  int stall_left = 0;

  // clock
  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  sorted_sequence_merge u_dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_func       (in_func),
    .in_value      (in_value),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_value_out (out_value_out),
    .out_last      (out_last),
    .out_empty_res (out_empty_res),
    .out_overflow  (out_overflow)
  );

  ssm_merge_checker u_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_func       (in_func),
    .in_value      (in_value),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_value_out (out_value_out),
    .out_last      (out_last),
    .out_empty_res (out_empty_res),
    .out_overflow  (out_overflow),
    .fail_count    (fail_count),
    .pending       (pending)
  );

  // result side back-pressure in random bursts
  always @(negedge clk) begin
    if (stall_left > 0) begin
      out_stall  <= 1'b1;
      stall_left = stall_left - 1;
    end else if (idle_on && $urandom_range(0, 7) == 0) begin
      out_stall  <= 1'b1;
      stall_left = $urandom_range(1, 18) - 1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  // one input transaction, entered and left at a falling edge
  task automatic push_item(input logic [1:0] func, input logic [31:0] value);
    int gap;
    gap = 0;
    if (idle_on && $urandom_range(0, 5) == 0) gap = $urandom_range(1, 18);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_func  <= func;
    in_value <= value;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
    if (func != FN_UNUSED) items_sent++;
  endtask

  initial begin : stimulus
    int          na;
    int          nb;
    int          shape;
    bit          broken;
    bit          narrow;
    bit          to_a;
    longint      cur_a;
    longint      cur_b;
    longint      step;
    logic [31:0] value;

    // reset
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed: empty merge, unused code, extremes and ties on both sides
    idle_on = 1'b1;
    push_item(FN_MERGE, 32'hFFFF_FFFF);
    push_item(FN_UNUSED, 32'h1234_5678);
    push_item(FN_APPEND_A, 32'h8000_0000);
    push_item(FN_APPEND_A, 32'hFFFF_FFFF);
    push_item(FN_APPEND_A, 32'h0000_0000);
    push_item(FN_APPEND_A, 32'h7FFF_FFFF);
    push_item(FN_APPEND_B, 32'h8000_0000);
    push_item(FN_APPEND_B, 32'h0000_0000);
    push_item(FN_APPEND_B, 32'h0000_0001);
    push_item(FN_APPEND_B, 32'h7FFF_FFFF);
    push_item(FN_UNUSED, 32'hFFFF_FFFF);
    push_item(FN_MERGE, 32'h0000_0000);
    // only b holds data
    push_item(FN_APPEND_B, 32'h0000_0005);
    push_item(FN_APPEND_B, 32'h0000_0005);
    push_item(FN_MERGE, 32'h5555_5555);
    // only a holds data
    push_item(FN_APPEND_A, 32'hAAAA_AAAA);
    push_item(FN_APPEND_A, 32'h5555_5555);
    push_item(FN_MERGE, 32'hAAAA_AAAA);
    push_item(FN_MERGE, 32'h0000_0000);

    // random: sorted (now and then unsorted) sequences per side, then a merge
    while (items_sent < RAND_ITEMS) begin
      idle_on = (items_sent < QUIET_FROM) && ($urandom_range(0, 3) != 0);
      shape   = $urandom_range(0, 9);
      if (shape == 0) begin
        // one side filled from one short of its depth to past it
        if ($urandom_range(0, 1)) begin
          na = $urandom_range(DEPTH - 1, DEPTH + 3);
          nb = $urandom_range(0, 3);
        end else begin
          na = $urandom_range(0, 3);
          nb = $urandom_range(DEPTH - 1, DEPTH + 3);
        end
      end else if (shape == 1) begin
        na = 0;
        nb = 0;
      end else begin
        na = $urandom_range(0, 6);
        nb = $urandom_range(0, 6);
      end
      broken = ($urandom_range(0, 7) == 0);
      narrow = ($urandom_range(0, 2) == 0);
      cur_a  = longint'($signed($urandom));
      cur_b  = narrow ? cur_a + $urandom_range(0, 3) : longint'($signed($urandom));
      while (na > 0 || nb > 0) begin
        // stray unused codes between appends
        if ($urandom_range(0, 11) == 0) push_item(FN_UNUSED, $urandom);
        to_a = (nb == 0) || (na > 0 && $urandom_range(0, 1));
        step = narrow ? $urandom_range(0, 2) : $urandom_range(0, 32'h00FF_FFFF);
        if (to_a) begin
          cur_a = cur_a + step;
          if (cur_a > ELEM_MAX) cur_a = ELEM_MAX;
          value = broken ? $urandom : cur_a[31:0];
          push_item(FN_APPEND_A, value);
          na--;
        end else begin
          cur_b = cur_b + step;
          if (cur_b > ELEM_MAX) cur_b = ELEM_MAX;
          value = broken ? $urandom : cur_b[31:0];
          push_item(FN_APPEND_B, value);
          nb--;
        end
      end
      push_item(FN_MERGE, $urandom);
    end
    in_valid <= 1'b0;
    idle_on = 1'b0;

    // drain, then allow for the block's own latency
    while (pending != 0) @(negedge clk);
    repeat (20) @(negedge clk);
    if (fail_count == 0) begin
      $display("** sorted_sequence_merge: PASSED **");
    end else begin
      $display("** sorted_sequence_merge: FAILED **");
    end
    $finish;
  end

  // watchdog
  initial begin
    #20_000_000;
    $display("** sorted_sequence_merge: FAILED **");
    $finish;
  end

endmodule
